/* hw/rtl/cds_pkg.sv */
// Shared types, codes and the status word decoder of the CiA 402 drive state sequencer.
package cds_pkg;

    // Drive states as decoded from the status word.
    typedef enum logic [2:0] {
        ST_DISABLED       = 3'd0,
        ST_READY          = 3'd1,
        ST_SWITCH_ON      = 3'd2,
        ST_ENABLED        = 3'd3,
        ST_QUICK_STOP     = 3'd4,
        ST_FAULT_REACTION = 3'd5,
        ST_FAULT          = 3'd6
    } drive_state_t;

    // State request codes.
    localparam logic [2:0] REQ_NONE      = 3'd0;
    localparam logic [2:0] REQ_DISABLED  = 3'd1;
    localparam logic [2:0] REQ_READY     = 3'd2;
    localparam logic [2:0] REQ_SWITCH_ON = 3'd3;
    localparam logic [2:0] REQ_ENABLED   = 3'd4;

    // Mode request code for no request.
    localparam logic [1:0] MREQ_NONE = 2'd0;

    // Control word bits.
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0001;
    localparam logic [15:0] CW_VOLTAGE     = 16'h0002;
    localparam logic [15:0] CW_QUICK_STOP  = 16'h0004;
    localparam logic [15:0] CW_ENABLE      = 16'h0008;
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

    // Cyclic mode codes: position, velocity, torque follow on from this base.
    localparam logic [7:0] MODE_BASE   = 8'd8;
    localparam logic [7:0] MODE_TORQUE = 8'd10;

    // Mode indexes.
    localparam logic [1:0] MIDX_POSITION = 2'd0;
    localparam logic [1:0] MIDX_VELOCITY = 2'd1;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 120;

    typedef struct packed {
        logic [15:0] drive_status;
        logic [7:0]  mode_display;
        logic [31:0] position_actual;
        logic [31:0] velocity_actual;
        logic [15:0] torque_actual;
        logic        state_request_valid;
        logic [2:0]  state_request;
        logic        mode_request_valid;
        logic [1:0]  mode_request;
    } in_item_t;

    typedef struct packed {
        logic [15:0]  drive_control;
        logic [7:0]   mode_of_operation;
        logic [31:0]  pos_setpoint;
        logic [31:0]  vel_setpoint;
        logic [15:0]  trq_setpoint;
        logic         targets_valid;
        drive_state_t drive_state_out;
        logic [1:0]   active_mode_out;
        logic [2:0]   pending_state_out;
        logic [1:0]   pending_mode_out;
    } result_t;

    // Bit 6 wins over everything; with bit 5 clear, bit 3 tells quick stop from fault.
    function automatic drive_state_t decode_state(input logic [15:0] sw);
        drive_state_t ds;
        if (sw[6]) begin
            ds = ST_DISABLED;
        end
        else if (sw[5]) begin
            if (!sw[1]) begin
                ds = ST_READY;
            end
            else if (!sw[2]) begin
                ds = ST_SWITCH_ON;
            end
            else begin
                ds = ST_ENABLED;
            end
        end
        else if (!sw[3]) begin
            ds = ST_QUICK_STOP;
        end
        else if (sw[2]) begin
            ds = ST_FAULT_REACTION;
        end
        else begin
            ds = ST_FAULT;
        end
        return ds;
    endfunction

endpackage

/* hw/rtl/cds_in_stage.sv */
// Input register of the drive state sequencer.
module cds_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cds_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              item_valid,
    output cds_pkg::in_item_t item
);
    import cds_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Space is free when the register is empty or its item moves on this cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/cds_core.sv */
// Sequencer state registers and the one-step next-state and result logic.
module cds_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  cds_pkg::in_item_t item,
    output cds_pkg::result_t  result
);
    import cds_pkg::*;

    drive_state_t decoded_state;
    logic [1:0]   active_mode_reg, active_mode_next;
    logic [2:0]   pending_state_reg, pending_state_next;
    logic [1:0]   pending_mode_reg, pending_mode_next;
    logic [15:0]  control_reg, control_next;
    logic [7:0]   mode_reg, mode_next;
    logic [31:0]  position_target_reg, position_target_next;
    logic [31:0]  velocity_target_reg, velocity_target_next;
    logic [15:0]  torque_target_reg, torque_target_next;

    logic         mode_step;
    logic         seed;
    logic [1:0]   seed_idx;
    logic [1:0]   want;

    always_comb
    begin
        pending_state_next   = pending_state_reg;
        pending_mode_next    = pending_mode_reg;
        active_mode_next     = active_mode_reg;
        control_next         = control_reg;
        mode_next            = mode_reg;
        position_target_next = position_target_reg;
        velocity_target_next = velocity_target_reg;
        torque_target_next   = torque_target_reg;
        mode_step            = 1'b0;
        seed                 = 1'b0;
        seed_idx             = MIDX_POSITION;
        want                 = pending_mode_reg;

        // New requests replace pending ones; an out-of-range state request is dropped.
        if (item.state_request_valid && item.state_request <= REQ_ENABLED) begin
            pending_state_next = item.state_request;
        end
        if (item.mode_request_valid) begin
            pending_mode_next = item.mode_request;
        end

        decoded_state = decode_state(item.drive_status);

        // The displayed cyclic mode is taken over only while operation is enabled.
        if (decoded_state == ST_ENABLED && item.mode_display >= MODE_BASE &&
            item.mode_display <= MODE_TORQUE) begin
            active_mode_next = item.mode_display[1:0];
        end

        case (decoded_state)
            ST_DISABLED:
            begin
                if (pending_state_next == REQ_DISABLED) begin
                    pending_state_next = REQ_NONE;
                end
                else if (pending_state_next == REQ_READY) begin
                    control_next = (control_reg & ~(CW_SWITCH_ON | CW_ENABLE | CW_FAULT_RESET))
                                   | CW_VOLTAGE | CW_QUICK_STOP;
                end
            end
            ST_READY:
            begin
                if (pending_state_next == REQ_READY) begin
                    control_next       = control_reg | CW_SWITCH_ON;
                    pending_state_next = REQ_SWITCH_ON;
                    seed               = 1'b1;
                    seed_idx           = MIDX_POSITION;
                end
            end
            ST_SWITCH_ON:
            begin
                if (pending_state_next == REQ_SWITCH_ON) begin
                    control_next       = control_reg | CW_ENABLE;
                    pending_state_next = REQ_ENABLED;
                end
            end
            ST_ENABLED:
            begin
                if (pending_state_next == REQ_ENABLED) begin
                    pending_state_next = REQ_NONE;
                    mode_step          = 1'b1;
                end
                else if (pending_state_next == REQ_DISABLED) begin
                    control_next = '0;
                end
                else begin
                    mode_step = 1'b1;
                end
            end
            ST_FAULT:
            begin
                if (pending_state_next == REQ_DISABLED) begin
                    control_next = CW_FAULT_RESET;
                end
                else begin
                    pending_state_next = REQ_NONE;
                end
            end
            default:
            begin
                pending_state_next = REQ_NONE;
            end
        endcase

        // A mode request is done once the drive displays it; until then the target is seeded.
        if (mode_step && pending_mode_next != MREQ_NONE) begin
            want = pending_mode_next - 2'd1;
            if (want == active_mode_next) begin
                pending_mode_next = MREQ_NONE;
            end
            else begin
                seed     = 1'b1;
                seed_idx = want;
            end
        end

        if (seed) begin
            mode_next = MODE_BASE + {6'd0, seed_idx};
            if (seed_idx == MIDX_POSITION) begin
                position_target_next = item.position_actual;
            end
            else if (seed_idx == MIDX_VELOCITY) begin
                velocity_target_next = item.velocity_actual;
            end
            else begin
                torque_target_next = item.torque_actual;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_mode_reg     <= MIDX_POSITION;
            pending_state_reg   <= REQ_NONE;
            pending_mode_reg    <= MREQ_NONE;
            control_reg         <= '0;
            mode_reg            <= '0;
            position_target_reg <= '0;
            velocity_target_reg <= '0;
            torque_target_reg   <= '0;
        end
        else if (advance) begin
            active_mode_reg     <= active_mode_next;
            pending_state_reg   <= pending_state_next;
            pending_mode_reg    <= pending_mode_next;
            control_reg         <= control_next;
            mode_reg            <= mode_next;
            position_target_reg <= position_target_next;
            velocity_target_reg <= velocity_target_next;
            torque_target_reg   <= torque_target_next;
        end
    end

    assign result.drive_control     = control_next;
    assign result.mode_of_operation = mode_next;
    assign result.pos_setpoint      = position_target_next;
    assign result.vel_setpoint      = velocity_target_next;
    assign result.trq_setpoint      = torque_target_next;
    assign result.targets_valid     = (decoded_state == ST_SWITCH_ON) ||
                                      (decoded_state == ST_ENABLED);
    assign result.drive_state_out   = decoded_state;
    assign result.active_mode_out   = active_mode_next;
    assign result.pending_state_out = pending_state_next;
    assign result.pending_mode_out  = pending_mode_next;

endmodule

/* hw/rtl/cds_out_stage.sv */
// Result register of the drive state sequencer.
module cds_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cds_pkg::result_t result,
    output logic             out_valid,
    input  logic             out_ready,
    output cds_pkg::result_t out_result
);
    import cds_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

/* hw/rtl/cia402_drive_state_sequencer.sv */
// Top level of the CiA 402 drive state sequencer: stream ports, input and result stages.
// An input item waits in the input register, then the sequencer step moves it into the result
// register as soon as that register is empty or its transaction is being taken.
// Throughput: one transaction per cycle while the master side takes each result as it comes.
// Reset (rst_n, asynchronous, active low) empties both stages and sets the mode to position,
// requests to none and all command registers to zero; the drive state is decoded afresh.
module cia402_drive_state_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0 up: drive_status[15:0], mode_display[23:16],
    // position_actual[55:24], velocity_actual[87:56], torque_actual[103:88],
    // state_request_valid[104], state_request[107:105], mode_request_valid[108],
    // mode_request[110:109], zero padding[111].
    input  logic [cds_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0 up: drive_control[15:0], mode_of_operation[23:16],
    // pos_setpoint[55:24], vel_setpoint[87:56], trq_setpoint[103:88],
    // targets_valid[104], drive_state_out[107:105], active_mode_out[109:108],
    // pending_state_out[112:110], pending_mode_out[114:113], zero padding[119:115].
    output logic [cds_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cds_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    result_t  result;
    result_t  out_result;

    // Unpack the slave transaction into its fields.
    assign in_item.drive_status        = s_axis_tdata[15:0];
    assign in_item.mode_display        = s_axis_tdata[23:16];
    assign in_item.position_actual     = s_axis_tdata[55:24];
    assign in_item.velocity_actual     = s_axis_tdata[87:56];
    assign in_item.torque_actual       = s_axis_tdata[103:88];
    assign in_item.state_request_valid = s_axis_tdata[104];
    assign in_item.state_request       = s_axis_tdata[107:105];
    assign in_item.mode_request_valid  = s_axis_tdata[108];
    assign in_item.mode_request        = s_axis_tdata[110:109];

    // An item moves into the result register, and updates the sequencer state, when the
    // result register is empty or its current transaction is being taken this cycle.
    assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

    cds_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cds_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    cds_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    // Pack the result fields into the master transaction, drive_control in the lowest bits.
    assign m_axis_tdata = {
        5'd0,
        out_result.pending_mode_out,
        out_result.pending_state_out,
        out_result.active_mode_out,
        out_result.drive_state_out,
        out_result.targets_valid,
        out_result.trq_setpoint,
        out_result.vel_setpoint,
        out_result.pos_setpoint,
        out_result.mode_of_operation,
        out_result.drive_control
    };

endmodule
